### hdl/char_lcd_stream_to_nibbles_macros.svh
// Assertion macros for the character LCD stream driver.
`ifndef CHAR_LCD_STREAM_TO_NIBBLES_MACROS_SVH
`define CHAR_LCD_STREAM_TO_NIBBLES_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CLCD_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define CLCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/clcd_pkg.sv
// Package: shared types and constants of the character LCD stream driver.
`default_nettype none
package clcd_pkg;

    // Control characters of the text stream
    localparam logic [7:0] CHR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHR_VTAB      = 8'h0B;
    localparam logic [7:0] CHR_FORMFEED  = 8'h0C;
    localparam logic [7:0] CHR_CR        = 8'h0D;

    // Display commands
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_LINE_TWO     = 8'hC0;
    localparam logic [7:0] CMD_SCROLL_LEFT  = 8'h18;
    localparam logic [7:0] CMD_SCROLL_RIGHT = 8'h1C;
    localparam logic [7:0] CMD_SET_ADDR     = 8'h80;
    localparam logic [7:0] ROW_STRIDE       = 8'h40;

    // Register select values
    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    // Configuration
    localparam int          MAX_COL_W       = 6;
    localparam logic [5:0]  MAX_COLUMN_RESET = 6'd16;
    localparam logic        REG_MAX_COLUMN  = 1'b0;   // word index of max_column

    // One register write on the display bus
    typedef struct packed {
        logic       rs;
        logic [7:0] value;
    } byte_wr_t;

    // Escape sequencer states
    typedef enum logic [2:0] {
        ESC_IDLE   = 3'b001,
        ESC_COLUMN = 3'b010,
        ESC_ROW    = 3'b100
    } esc_state_t;

endpackage
`default_nettype wire

### hdl/clcd_cfg.sv
// Configuration register block: APB-style access to max_column.
`default_nettype none
module clcd_cfg (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [clcd_pkg::MAX_COL_W-1:0] max_column
);

    logic [clcd_pkg::MAX_COL_W-1:0] max_column_reg;
    logic [clcd_pkg::MAX_COL_W-1:0] max_column_next;
    logic                           hit;

    assign pready = 1'b1;
    assign hit    = (paddr[2] == clcd_pkg::REG_MAX_COLUMN);

    always_comb begin
        max_column_next = max_column_reg;
        if (psel && penable && pwrite && pready && hit) begin
            max_column_next = pwdata[clcd_pkg::MAX_COL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_column_reg <= clcd_pkg::MAX_COLUMN_RESET;
        end else begin
            max_column_reg <= max_column_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata = {{(32-clcd_pkg::MAX_COL_W){1'b0}}, max_column_reg};
        end
    end

    assign max_column = max_column_reg;

endmodule
`default_nettype wire

### hdl/clcd_decode.sv
// Input register, escape sequencer and byte-to-command decode.
`default_nettype none
module clcd_decode (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic [clcd_pkg::MAX_COL_W-1:0] max_column,
    input  wire logic        out_free,
    output logic             wr_load,
    output clcd_pkg::byte_wr_t wr
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [7:0]           byte_reg;
    logic [7:0]           byte_next;
    clcd_pkg::esc_state_t esc_reg;
    clcd_pkg::esc_state_t esc_next;
    logic [7:0]           col_reg;
    logic [7:0]           col_next;

    logic                 yields;
    logic                 advance;
    logic [7:0]           col_dec;
    logic [7:0]           col_clip;
    logic                 row_bit;
    logic [7:0]           cursor_cmd;

    // Cursor address: decrement, clip, add line offset
    always_comb begin
        col_dec  = col_reg - 8'd1;
        col_clip = (col_dec > {2'b00, max_column}) ? {2'b00, max_column} : col_dec;
        row_bit  = (byte_reg != 8'd1);
        cursor_cmd = clcd_pkg::CMD_SET_ADDR + col_clip
                   + (row_bit ? clcd_pkg::ROW_STRIDE : 8'h00);
    end

    always_comb begin
        yields   = 1'b1;
        esc_next = clcd_pkg::ESC_IDLE;
        col_next = col_reg;
        wr.rs    = clcd_pkg::RS_COMMAND;
        wr.value = byte_reg;
        unique case (esc_reg)
            clcd_pkg::ESC_COLUMN: begin
                yields   = 1'b0;
                col_next = byte_reg;
                esc_next = clcd_pkg::ESC_ROW;
            end
            clcd_pkg::ESC_ROW: begin
                wr.value = cursor_cmd;
            end
            default: begin
                case (byte_reg)
                    clcd_pkg::CHR_CR:        wr.value = clcd_pkg::CMD_CLEAR;
                    clcd_pkg::CHR_NEWLINE:   wr.value = clcd_pkg::CMD_LINE_TWO;
                    clcd_pkg::CHR_FORMFEED:  wr.value = clcd_pkg::CMD_SCROLL_LEFT;
                    clcd_pkg::CHR_BACKSPACE: wr.value = clcd_pkg::CMD_SCROLL_RIGHT;
                    clcd_pkg::CHR_VTAB: begin
                        yields   = 1'b0;
                        esc_next = clcd_pkg::ESC_COLUMN;
                    end
                    default: begin
                        wr.rs = clcd_pkg::RS_DATA;
                    end
                endcase
            end
        endcase
    end

    assign advance  = in_valid_reg && (!yields || out_free);
    assign wr_load  = in_valid_reg && yields && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        byte_next     = byte_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            byte_next     = s_tdata;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            esc_reg      <= clcd_pkg::ESC_IDLE;
            col_reg      <= 8'h00;
        end else begin
            in_valid_reg <= in_valid_next;
            if (advance) begin
                esc_reg <= esc_next;
                col_reg <= col_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

endmodule
`default_nettype wire

### hdl/clcd_nib_out.sv
// Output register: sends one byte write as two nibble transfers.
`default_nettype none
module clcd_nib_out (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        wr_load,
    input  wire clcd_pkg::byte_wr_t wr,
    output logic             out_free,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tuser,
    output logic             m_tlast
);

    logic                 valid_reg;
    logic                 valid_next;
    logic                 lo_reg;
    logic                 lo_next;
    clcd_pkg::byte_wr_t   wr_reg;
    clcd_pkg::byte_wr_t   wr_next;

    // Free once empty or while the low nibble leaves
    assign out_free = !valid_reg || (lo_reg && m_tready);

    always_comb begin
        valid_next = valid_reg;
        lo_next    = lo_reg;
        wr_next    = wr_reg;
        if (wr_load) begin
            valid_next = 1'b1;
            lo_next    = 1'b0;
            wr_next    = wr;
        end else if (valid_reg && m_tready) begin
            if (lo_reg) begin
                valid_next = 1'b0;
            end else begin
                lo_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            lo_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            lo_reg    <= lo_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_reg <= wr_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'h0, (lo_reg ? wr_reg.value[3:0] : wr_reg.value[7:4])};
    assign m_tuser  = wr_reg.rs;
    assign m_tlast  = lo_reg;

endmodule
`default_nettype wire

### hdl/char_lcd_stream_to_nibbles.sv
// Top level of the character LCD stream driver.
`default_nettype none
`include "char_lcd_stream_to_nibbles_macros.svh"
// Turns a stream of text bytes into 4-bit display bus writes. Each byte that
// produces a write yields two transfers on the m_ side, high nibble first,
// both carrying the same register-select bit on m_tuser; m_tlast marks the
// low nibble. Carriage return clears the display, newline jumps to the start
// of line two, form feed and backspace scroll left and right, and vertical tab
// starts a cursor escape: the tab and the column byte after it produce no
// transfer of their own, and the row byte sends the set-address command. Every
// other byte is written as character data. Timing: a byte enters an input
// register, is decoded combinationally and is loaded into the output register
// once that register is free; the first nibble is then offered from the output
// register. The output register drains each byte write as two nibble
// transfers, which limits the sustained byte rate; escape bytes that produce
// nothing pass without waiting for the output register. A new byte is taken
// while the previous write is still draining.
// max_column sits at APB address 0 and resets to 16.
module char_lcd_stream_to_nibbles (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // text input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    // nibble output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [3:0] nibble, [7:4] zero
    output logic             m_tuser,   // [0] register_select
    output logic             m_tlast,   // last_of_byte
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [clcd_pkg::MAX_COL_W-1:0] max_column;
    logic                           out_free;
    logic                           wr_load;
    clcd_pkg::byte_wr_t             wr;
    logic                           hi_xfer;

    // Register block
    clcd_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .max_column (max_column)
    );

    // Hold the incoming byte, run the escape sequencer, pick the command
    clcd_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .max_column (max_column),
        .out_free   (out_free),
        .wr_load    (wr_load),
        .wr         (wr)
    );

    // Split each byte write into two nibble transfers
    clcd_nib_out u_nib_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_load  (wr_load),
        .wr       (wr),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // High nibble transfer
    assign hi_xfer = m_tvalid && m_tready && !m_tlast;

    // The low nibble follows the high nibble at once, same register select
    `CLCD_ASSERT_NEXT(a_lo_follows, aclk, aresetn, hi_xfer, m_tvalid && m_tlast)
    `CLCD_ASSERT_NEXT(a_rs_kept, aclk, aresetn, hi_xfer, m_tuser == $past(m_tuser))
    // Input stalls only behind a busy output register
    `CLCD_ASSERT_IMPLY(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid)

endmodule
`default_nettype wire
